[rtl/core/assert_macros.svh]
// Assertion helpers for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ISS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/iss_pkg.sv]
`default_nettype none

package iss_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int POS_W       = 4;
    localparam int ENTRY_W     = 5;

    typedef logic [1:0] action_t;
    typedef logic [1:0] status_t;

    localparam action_t ACT_PUSH   = 2'd0;
    localparam action_t ACT_POP    = 2'd1;
    localparam action_t ACT_SEARCH = 2'd2;

    localparam status_t STAT_OK    = 2'd0;
    localparam status_t STAT_EMPTY = 2'd1;
    localparam status_t STAT_FULL  = 2'd2;

endpackage

`default_nettype wire

[rtl/core/iss_ram.sv]
`default_nettype none

module iss_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/integer_stack_with_search_unit.sv]
// Bounded stack of signed 32-bit integers with a top-down search.
// Command channel: an item (action, operand_value) is taken at a rising edge
// where start is high and busy is low. Actions are push, pop and search.
// Result channel: done is high for exactly one cycle and the result ports are
// valid in that cycle. The receiver cannot stall, so results are never held.
// Every item gives one result, which always carries the entry count after it.
// Latency: push, an unknown action, a pop on empty and a search on empty give
// their result in the cycle after acceptance, and busy stays low.
// A pop issues the read of the top entry at acceptance; the entry memory
// registers it, and S_POP then registers it as the result with done.
// A search reads one entry per cycle from the top down, at most STACK_DEPTH
// entries, and stops at the first match or at the bottom entry; busy stays
// high until its result, and the single memory read port sets this rate.
// Reset clears the entry count and the control state; the entry memory is not
// cleared, since only entries written by a push are ever read.
`default_nettype none

`include "assert_macros.svh"

module integer_stack_with_search_unit
    import iss_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               action,
    input  wire logic signed [DATA_W-1:0] operand_value,
    output logic                          done,
    output logic signed [DATA_W-1:0]      popped_value,
    output logic                          found,
    output logic [POS_W-1:0]              found_position,
    output logic [ENTRY_W-1:0]            entry_count,
    output logic [1:0]                    status
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_POP    = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         count_dec;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic [DATA_W-1:0]        key_reg, key_next;
    logic                     done_reg, done_next;
    logic signed [DATA_W-1:0] popped_value_reg, popped_value_next;
    logic                     found_reg, found_next;
    logic [POS_W-1:0]         found_position_reg, found_position_next;
    logic [ENTRY_W-1:0]       entry_count_reg, entry_count_next;
    status_t                  status_reg, status_next;

    logic                     accept;
    logic                     full;
    logic                     empty;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [DATA_W-1:0]        wr_data;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic [DATA_W-1:0]        rd_data;

    iss_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign full      = (count_reg == CNT_W'(STACK_DEPTH));
    assign empty     = (count_reg == '0);
    assign count_dec = count_reg - 1'b1;

    always_comb
    begin
        state_next          = state_reg;
        count_next          = count_reg;
        idx_next            = idx_reg;
        key_next            = key_reg;
        done_next           = 1'b0;
        popped_value_next   = '0;
        found_next          = 1'b0;
        found_position_next = '0;
        status_next         = STAT_OK;
        wr_en               = 1'b0;
        wr_addr             = count_reg[ADDR_W-1:0];
        wr_data             = operand_value;
        rd_en               = 1'b0;
        rd_addr             = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        ACT_PUSH:
                        begin
                            done_next = 1'b1;
                            if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ACT_POP:
                        begin
                            if (empty)
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = count_dec[ADDR_W-1:0];
                                count_next = count_dec;
                                state_next = S_POP;
                            end
                        end
                        ACT_SEARCH:
                        begin
                            if (empty)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = count_dec[ADDR_W-1:0];
                                idx_next   = count_dec[ADDR_W-1:0];
                                key_next   = operand_value;
                                state_next = S_SEARCH;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                done_next         = 1'b1;
                popped_value_next = rd_data;
                state_next        = S_IDLE;
            end
            S_SEARCH:
            begin
                if (rd_data == key_reg)
                begin
                    done_next           = 1'b1;
                    found_next          = 1'b1;
                    found_position_next = POS_W'(idx_reg);
                    state_next          = S_IDLE;
                end
                else if (idx_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg - 1'b1;
                    idx_next = idx_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        entry_count_next = ENTRY_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        key_reg <= key_next;
        if (done_next)
        begin
            popped_value_reg   <= popped_value_next;
            found_reg          <= found_next;
            found_position_reg <= found_position_next;
            entry_count_reg    <= entry_count_next;
            status_reg         <= status_next;
        end
    end

    assign done           = done_reg;
    assign popped_value   = popped_value_reg;
    assign found          = found_reg;
    assign found_position = found_position_reg;
    assign entry_count    = entry_count_reg;
    assign status         = status_reg;

    `ISS_ASSERT_SAME(a_count_bounded, clk, rst_n, 1'b1, count_reg <= CNT_W'(STACK_DEPTH))
    `ISS_ASSERT_SAME(a_full_flag, clk, rst_n, done_reg && (status_reg == STAT_FULL),
                     count_reg == CNT_W'(STACK_DEPTH))
    `ISS_ASSERT_NEXT(a_push_counts, clk, rst_n, accept && (action == ACT_PUSH) && !full,
                     count_reg == $past(count_reg) + 1'b1)
    `ISS_ASSERT_SAME(a_busy_no_write, clk, rst_n, busy, !wr_en)

endmodule

`default_nettype wire

[tb/sv/integer_stack_with_search_unit_tb.sv]
`timescale 1ns / 1ps

module integer_stack_with_search_unit_tb
    import iss_pkg::*;
();

    localparam action_t ACT_UNUSED  = 2'd3;
    localparam int      MAX_REPORTS = 10;
    localparam int      SETTLE_CYCLES = STACK_DEPTH + 4;

    typedef struct {
        logic signed [DATA_W-1:0] popped_value;
        logic                     found;
        logic [POS_W-1:0]         found_position;
        logic [ENTRY_W-1:0]       entry_count;
        status_t                  status;
    } stack_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    action_t                  action = ACT_PUSH;
    logic signed [DATA_W-1:0] operand_value = '0;

    logic                     busy;
    logic                     done;
    logic signed [DATA_W-1:0] popped_value;
    logic                     found;
    logic [POS_W-1:0]         found_position;
    logic [ENTRY_W-1:0]       entry_count;
    logic [1:0]               status;

    logic signed [DATA_W-1:0] stack_mem [STACK_DEPTH];
    int                       stack_fill = 0;
    stack_result_t            expected_results [$];

    int mismatch_count = 0;
    int push_count = 0;
    int full_push_count = 0;
    int pop_count = 0;
    int empty_pop_count = 0;
    int hit_count = 0;
    int miss_count = 0;
    int unused_count = 0;

    integer_stack_with_search_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .operand_value  (operand_value),
        .done           (done),
        .popped_value   (popped_value),
        .found          (found),
        .found_position (found_position),
        .entry_count    (entry_count),
        .status         (status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic stack_result_t apply_command(input action_t act,
                                                    input logic signed [DATA_W-1:0] value);
        stack_result_t res;
        res.popped_value   = '0;
        res.found          = 1'b0;
        res.found_position = '0;
        res.status         = STAT_OK;
        case (act)
            ACT_PUSH:
            begin
                if (stack_fill >= STACK_DEPTH)
                begin
                    res.status = STAT_FULL;
                    full_push_count++;
                end
                else
                begin
                    stack_mem[ADDR_W'(stack_fill)] = value;
                    stack_fill++;
                    push_count++;
                end
            end
            ACT_POP:
            begin
                if (stack_fill == 0)
                begin
                    res.status = STAT_EMPTY;
                    empty_pop_count++;
                end
                else
                begin
                    stack_fill--;
                    res.popped_value = stack_mem[ADDR_W'(stack_fill)];
                    pop_count++;
                end
            end
            ACT_SEARCH:
            begin
                for (int k = stack_fill - 1; k >= 0; k--)
                begin
                    if (stack_mem[ADDR_W'(k)] == value)
                    begin
                        res.found          = 1'b1;
                        res.found_position = POS_W'(k);
                        break;
                    end
                end
                if (res.found)
                    hit_count++;
                else
                    miss_count++;
            end
            default:
                unused_count++;
        endcase
        res.entry_count = ENTRY_W'(stack_fill);
        return res;
    endfunction

    function automatic logic signed [DATA_W-1:0] random_operand();
        logic signed [DATA_W-1:0] value;
        case ($urandom_range(9, 0))
            0:       value = 32'sh8000_0000;
            1:       value = 32'sh7fff_ffff;
            2, 3, 4: value = $urandom_range(16, 0) - 8;
            default: value = $urandom;
        endcase
        return value;
    endfunction

    task automatic send_item(input action_t act, input logic signed [DATA_W-1:0] value);
        start         <= 1'b1;
        action        <= act;
        operand_value <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_results.push_back(apply_command(act, value));
    endtask

    task automatic idle_sender(input int cycles);
        start         <= 1'b0;
        action        <= action_t'($urandom);
        operand_value <= $urandom;
        repeat (cycles)
            @(posedge clk);
    endtask

    task automatic wait_until_idle();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic test_empty_stack();
        send_item(ACT_POP, 32'sh7fff_ffff);
        send_item(ACT_SEARCH, -1);
        send_item(ACT_UNUSED, 32'sh7fff_ffff);
    endtask

    task automatic test_fill_to_capacity();
        logic signed [DATA_W-1:0] fill_vals [STACK_DEPTH] = '{
            32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 5, 11, 22, 33,
            44, 55, 66, 5, 77, 88, 99, 32'sh1234_5678
        };
        foreach (fill_vals[i])
            send_item(ACT_PUSH, fill_vals[i]);
        send_item(ACT_PUSH, 32'sh0bad_cafe);
        send_item(ACT_SEARCH, 32'sh8000_0000);
        send_item(ACT_SEARCH, 32'sh1234_5678);
        send_item(ACT_SEARCH, 5);
        send_item(ACT_SEARCH, 123);
        send_item(ACT_POP, 0);
        send_item(ACT_POP, -1);
    endtask

    task automatic test_random_traffic(input int n_items, input bit with_gaps);
        int                       mode;
        int                       roll;
        int                       push_pct;
        int                       pop_pct;
        action_t                  act;
        logic signed [DATA_W-1:0] value;
        mode = $urandom_range(2, 0);
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(39, 0) == 0)
                mode = $urandom_range(2, 0);
            case (mode)
                0:       begin push_pct = 55; pop_pct = 20; end
                1:       begin push_pct = 20; pop_pct = 55; end
                default: begin push_pct = 35; pop_pct = 35; end
            endcase
            roll = $urandom_range(99, 0);
            if (roll < push_pct)
                act = ACT_PUSH;
            else if (roll < push_pct + pop_pct)
                act = ACT_POP;
            else if (roll < 97)
                act = ACT_SEARCH;
            else
                act = ACT_UNUSED;
            if (act == ACT_SEARCH && stack_fill > 0 && $urandom_range(9, 0) < 6)
                value = stack_mem[ADDR_W'($urandom_range(stack_fill - 1, 0))];
            else
                value = random_operand();
            send_item(act, value);
            if (with_gaps && $urandom_range(3, 0) == 0)
                idle_sender($urandom_range(14, 1));
            if (i == n_items / 2)
                wait_until_idle();
        end
    endtask

    always @(posedge clk)
    begin : result_check
        stack_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("Result at %0t arrived with no item outstanding.", $realtime);
            end
            else
            begin
                want = expected_results.pop_front();
                if (popped_value !== want.popped_value || found !== want.found
                    || found_position !== want.found_position
                    || entry_count !== want.entry_count || status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("Mismatch at %0t: expected value %0d found %0b pos %0d count %0d status %0d,",
                                 $realtime, want.popped_value, want.found,
                                 want.found_position, want.entry_count, want.status);
                        $display("    got value %0d found %0b pos %0d count %0d status %0d.",
                                 popped_value, found, found_position, entry_count, status);
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_stack();
        wait_until_idle();
        test_fill_to_capacity();
        wait_until_idle();
        test_random_traffic(1400, 1'b1);
        wait_until_idle();
        test_random_traffic(300, 1'b0);
        wait_until_idle();
        $display("Ran %0d pushes (%0d onto a full stack) and %0d pops (%0d on an empty stack).",
                 push_count, full_push_count, pop_count, empty_pop_count);
        $display("Ran %0d searches with a match, %0d without, and %0d unused actions.",
                 hit_count, miss_count, unused_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
